@@ design/stq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry queue - shared definitions
// Types, codes and helpers used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Field widths fixed by the stream format.
    localparam int ID_W       = 4;
    localparam int TICK_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CMD_W      = 2;
    localparam int ACT_W      = 2;
    localparam int ID_SPACE   = 16;
    localparam int SLOTS_DEF  = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // Offset added to the current tick when the new head is already due.
    localparam logic [TICK_W-1:0] ARM_GUARD = TICK_W'(2);

    // Command codes carried on the input tuser.
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // Compare actions reported with each result.
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ARM   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Result status codes.
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_INVALID = 1'b1;

    // Operation applied to every cell in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    // One queue entry as held by a cell.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] expiry;
    } t_entry;

    // Control broadcast to all cells.
    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tick;
    } t_cell_ctl;

    // Wrap-aware order: a is before b when the difference is negative.
    function automatic logic tick_before(input logic [TICK_W-1:0] a,
                                         input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return diff[TICK_W-1];
    endfunction

endpackage

@@ design/stq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry queue - queue cell
// Holds one queue position and shifts with its neighbors on insert and removal.
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_ctl i_ctl,
    input  stq_pkg::t_entry    i_prev,
    input  stq_pkg::t_entry    i_next,
    input  logic               i_ins_found,
    input  logic               i_del_found,
    output stq_pkg::t_entry    o_entry,
    output logic               o_ins_found,
    output logic               o_del_found
);
    import stq_pkg::*;

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [TICK_W-1:0] r_expiry;
    t_entry            n_entry;
    logic              ins_here;
    logic              del_here;

    // The new tick goes in front of this entry, or this position is free.
    assign ins_here    = !r_valid || tick_before(i_ctl.tick, r_expiry);
    assign del_here    = r_valid && (r_id == i_ctl.id);
    assign o_ins_found = i_ins_found || ins_here;
    assign o_del_found = i_del_found || del_here;
    assign o_entry     = '{valid: r_valid, id: r_id, expiry: r_expiry};

    // Next content: hold, take the upstream or downstream neighbor, or the new timer.
    always_comb begin
        n_entry = o_entry;
        unique case (i_ctl.op)
            OP_HOLD: begin
                n_entry = o_entry;
            end
            OP_INSERT: begin
                if (i_ins_found) begin
                    n_entry = i_prev;
                end else if (ins_here) begin
                    n_entry = '{valid: 1'b1, id: i_ctl.id, expiry: i_ctl.tick};
                end
            end
            OP_DELETE: begin
                if (o_del_found) begin
                    n_entry = i_next;
                end
            end
            OP_POP: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    // Occupancy is reset; the payload is only meaningful while valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_entry.id;
        r_expiry <= n_entry.expiry;
    end

endmodule

@@ design/stq_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry queue - cell chain
// A row of queue cells kept in expiry order, head at cell zero.
// ----------------------------------------------------------------------------
module stq_chain #(
    parameter int N_CELLS = stq_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_ctl i_ctl,
    output stq_pkg::t_entry    o_head,
    output stq_pkg::t_entry    o_second,
    output logic               o_head_ins,
    output logic               o_head_del,
    output logic               o_queued
);
    import stq_pkg::*;

    t_entry entry    [N_CELLS];
    t_entry prev_in  [N_CELLS];
    t_entry next_in  [N_CELLS];
    logic   ins_f    [N_CELLS+1];
    logic   del_f    [N_CELLS+1];

    assign ins_f[0] = 1'b0;
    assign del_f[0] = 1'b0;

    // Wire each cell to its neighbors; the ends see empty entries.
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign prev_in[g] = '0;
        end else begin : g_mid
            assign prev_in[g] = entry[g-1];
        end
        if (g == N_CELLS - 1) begin : g_last
            assign next_in[g] = '0;
        end else begin : g_inner
            assign next_in[g] = entry[g+1];
        end

        stq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_prev      (prev_in[g]),
            .i_next      (next_in[g]),
            .i_ins_found (ins_f[g]),
            .i_del_found (del_f[g]),
            .o_entry     (entry[g]),
            .o_ins_found (ins_f[g+1]),
            .o_del_found (del_f[g+1])
        );
    end

    // Status seen by the sequencer.
    assign o_head     = entry[0];
    assign o_second   = entry[1];
    assign o_head_ins = ins_f[1];
    assign o_head_del = del_f[1];
    assign o_queued   = del_f[N_CELLS];

endmodule

@@ design/sorted_timer_expiry_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry queue
// Keeps timers ordered by expiry in a cell chain and reports compare updates.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one command word per transfer: tuser carries the
//   command (start, stop, expire, no operation), tdata the timer id, the
//   expiry tick and the current tick. The master stream returns result
//   words; tlast marks the final word of a command and tuser flags a word
//   that reports an expired timer.
//   Start, stop and no-op give one word, registered on accept;
//   all cells compare and shift in that same cycle, so these commands can
//   be taken one per cycle while the master side keeps up.
//   An expire event gives one word per expired timer and a closing word:
//   the head cell is checked and popped once per cycle while the output can
//   take a word, and the next command is taken after the closing word.
//   A new command is taken only when the output register is empty or being
//   read; a stalled receiver holds the word and stalls the slave side.
//   Reset empties the queue and clears the expire event counter.
// ----------------------------------------------------------------------------
module sorted_timer_expiry_queue_unit #(
    parameter int TIMER_SLOTS = stq_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // timer_id[3:0], expiry_tick[35:4], now[67:36], zero pad above
    input  logic [stq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [stq_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // fired_id[3:0], status[4], compare_action[6:5], compare_value[38:7],
    // interrupt_count[70:39], zero pad above
    output logic [stq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // fired[0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import stq_pkg::*;

    localparam int N_CELLS = (TIMER_SLOTS < ID_SPACE) ? TIMER_SLOTS : ID_SPACE;
    localparam logic [ID_W:0] USABLE = (ID_W+1)'(N_CELLS);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_EXPIRE = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [TICK_W-1:0] r_now;
    logic [CNT_W-1:0]  r_isr;
    logic              r_ov;
    logic              r_fired;
    logic [ID_W-1:0]   r_fid;
    logic              r_status;
    logic [ACT_W-1:0]  r_action;
    logic [TICK_W-1:0] r_value;
    logic              r_last;

    logic              n_fired;
    logic [ID_W-1:0]   n_fid;
    logic              n_status;
    logic [ACT_W-1:0]  n_action;
    logic [TICK_W-1:0] n_value;
    logic              n_last;
    logic              load;

    logic [ID_W-1:0]   in_id;
    logic [TICK_W-1:0] in_tick;
    logic [TICK_W-1:0] in_now;
    logic              out_free;
    logic              accept;
    logic              id_ok;

    t_cell_ctl         ctl;
    t_entry            head, second;
    logic              head_ins, head_del, queued;

    assign in_id   = s_axis_tdata[ID_W-1:0];
    assign in_tick = s_axis_tdata[ID_W +: TICK_W];
    assign in_now  = s_axis_tdata[ID_W+TICK_W +: TICK_W];

    assign out_free      = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign id_ok         = {1'b0, in_id} < USABLE;

    stq_chain #(.N_CELLS(N_CELLS)) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_head     (head),
        .o_second   (second),
        .o_head_ins (head_ins),
        .o_head_del (head_del),
        .o_queued   (queued)
    );

    // Command sequencing and the next result word.
    always_comb begin
        n_state  = r_state;
        ctl      = '{op: OP_HOLD, id: in_id, tick: in_tick};
        load     = 1'b0;
        n_fired  = 1'b0;
        n_fid    = '0;
        n_status = ST_OK;
        n_action = ACT_NONE;
        n_value  = '0;
        n_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        CMD_START: begin
                            load = 1'b1;
                            if (!id_ok || queued) begin
                                n_status = ST_INVALID;
                            end else begin
                                ctl.op = OP_INSERT;
                                if (head_ins) begin
                                    n_action = ACT_ARM;
                                    n_value  = (in_now < in_tick) ? in_tick
                                                                  : in_now + ARM_GUARD;
                                end
                            end
                        end
                        CMD_STOP: begin
                            load = 1'b1;
                            if (id_ok && queued) begin
                                ctl.op = OP_DELETE;
                                if (head_del) begin
                                    if (second.valid) begin
                                        n_action = ACT_ARM;
                                        n_value  = second.expiry;
                                    end else begin
                                        n_action = ACT_CLEAR;
                                    end
                                end
                            end
                        end
                        CMD_EXPIRE: begin
                            n_state = S_EXPIRE;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_EXPIRE: begin
                // Check the head once per cycle while the output can take a word.
                if (out_free) begin
                    load = 1'b1;
                    if (head.valid && !tick_before(r_now, head.expiry)) begin
                        ctl.op  = OP_POP;
                        n_fired = 1'b1;
                        n_fid   = head.id;
                        n_last  = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                        if (head.valid) begin
                            n_action = ACT_ARM;
                            n_value  = head.expiry;
                        end else begin
                            n_action = ACT_CLEAR;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_isr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (s_axis_tuser == CMD_EXPIRE)) begin
                r_isr <= r_isr + CNT_W'(1);
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Result word and the tick latched for an expire event.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= in_now;
        end
        if (load) begin
            r_fired  <= n_fired;
            r_fid    <= n_fid;
            r_status <= n_status;
            r_action <= n_action;
            r_value  <= n_value;
            r_last   <= n_last;
        end
    end

    // Output stream.
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_isr, r_value, r_action, r_status, r_fid};
    assign m_axis_tuser  = r_fired;
    assign m_axis_tlast  = r_last;

endmodule

@@ design/stq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry queue - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module stq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [stq_pkg::CMD_W-1:0]      s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [stq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);
    import stq_pkg::*;

    // A word that is not taken stays on the bus.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // No command is taken while a result word waits for the receiver.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("command taken while result pending");

    // A fired timer word never closes a command.
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("fired word marked last");

    // A fired timer word carries no status and no compare change.
    a_fired_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[4] == ST_OK) && (m_axis_tdata[6:5] == ACT_NONE))
        else $error("fired word with status or compare action");

    // The event count moves only when an expire command is taken.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_EXPIRE))
            |=> $stable(m_axis_tdata[70:39]))
        else $error("event count changed without an expire command");

endmodule

bind sorted_timer_expiry_queue_unit stq_checker u_stq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ bench/sorted_timer_expiry_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry queue - self-checking testbench
// Drives start, stop, expire and no-op command words into the queue and
// checks every result word against a timer queue model kept in the bench.
// A directed part covers the ordering and compare-arming corner cases; a
// random part runs mostly well-formed timer traffic with random content,
// under three back-pressure profiles on the two streams.
// ----------------------------------------------------------------------------
module sorted_timer_expiry_queue_unit_test;
    import stq_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int USABLE_IDS  = (SLOTS_DEF < ID_SPACE) ? SLOTS_DEF : ID_SPACE;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    // One result word as seen on the master stream.
    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic              status;
        logic [ACT_W-1:0]  action;
        logic [TICK_W-1:0] value;
        logic [CNT_W-1:0]  irq_count;
        logic              last;
    } t_result_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // timer_id[3:0], expiry_tick[35:4], now[67:36], zero pad above
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // command[1:0]
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // fired_id[3:0], status[4], compare_action[6:5], compare_value[38:7],
    // interrupt_count[70:39], zero pad above
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // fired[0]
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // Model of the timer queue.
    logic [ID_W-1:0]   model_order [USABLE_IDS];
    logic [TICK_W-1:0] model_expiry [USABLE_IDS];
    logic              model_queued [USABLE_IDS];
    int unsigned       model_length;
    logic [CNT_W-1:0]  model_irq_count;

    t_result_word expected_words [$];
    int           mismatches;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    int unsigned  cycle_count;
    logic [TICK_W-1:0] sim_now;

    sorted_timer_expiry_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Every input known from time zero.
    initial begin
        i_rst_n            = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = CMD_NOP;
        m_axis_tready      = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cycle_count        = 0;
        mismatches         = 0;
        sim_now            = '0;
        model_length       = 0;
        model_irq_count    = '0;
        for (int i = 0; i < USABLE_IDS; i++) begin
            model_queued[i] = 1'b0;
        end
    end

    // Wrap-aware order: a comes first when a - b is negative.
    function automatic logic expires_first(input logic [TICK_W-1:0] a,
                                           input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] delta;
        delta = a - b;
        return delta[TICK_W-1];
    endfunction

    function automatic void push_result(input logic fired, input logic [ID_W-1:0] fid,
                                        input logic status, input logic [ACT_W-1:0] act,
                                        input logic [TICK_W-1:0] value, input logic last);
        t_result_word w;
        w.fired     = fired;
        w.fired_id  = fid;
        w.status    = status;
        w.action    = act;
        w.value     = value;
        w.irq_count = model_irq_count;
        w.last      = last;
        expected_words.push_back(w);
    endfunction

    function automatic void drop_queue_entry(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < model_length; i++) begin
            model_order[i] = model_order[i+1];
        end
        model_length--;
    endfunction

    // Apply one accepted command to the model and queue its result words.
    function automatic void predict_timer_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [TICK_W-1:0] tick,
                                                  input logic [TICK_W-1:0] now_val);
        int unsigned pos;
        logic [ID_W-1:0] head;
        case (cmd)
            CMD_START: begin
                if (int'(id) >= USABLE_IDS || model_queued[id]) begin
                    push_result(1'b0, '0, ST_INVALID, ACT_NONE, '0, 1'b1);
                end else begin
                    model_expiry[id] = tick;
                    pos = model_length;
                    for (int unsigned i = 0; i < model_length; i++) begin
                        if (expires_first(tick, model_expiry[model_order[i]])) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int unsigned i = model_length; i > pos; i--) begin
                        model_order[i] = model_order[i-1];
                    end
                    model_order[pos] = id;
                    model_length++;
                    model_queued[id] = 1'b1;
                    if (pos == 0) begin
                        push_result(1'b0, '0, ST_OK, ACT_ARM,
                                    (now_val < tick) ? tick : now_val + ARM_GUARD, 1'b1);
                    end else begin
                        push_result(1'b0, '0, ST_OK, ACT_NONE, '0, 1'b1);
                    end
                end
            end
            CMD_STOP: begin
                if (int'(id) >= USABLE_IDS || !model_queued[id]) begin
                    push_result(1'b0, '0, ST_OK, ACT_NONE, '0, 1'b1);
                end else begin
                    pos = 0;
                    for (int unsigned i = 0; i < model_length; i++) begin
                        if (model_order[i] == id) begin
                            pos = i;
                            break;
                        end
                    end
                    drop_queue_entry(pos);
                    model_queued[id] = 1'b0;
                    if (pos != 0) begin
                        push_result(1'b0, '0, ST_OK, ACT_NONE, '0, 1'b1);
                    end else if (model_length > 0) begin
                        push_result(1'b0, '0, ST_OK, ACT_ARM,
                                    model_expiry[model_order[0]], 1'b1);
                    end else begin
                        push_result(1'b0, '0, ST_OK, ACT_CLEAR, '0, 1'b1);
                    end
                end
            end
            CMD_EXPIRE: begin
                model_irq_count++;
                // Pop every head that is due at this one value of now.
                while (model_length > 0) begin
                    head = model_order[0];
                    if (expires_first(now_val, model_expiry[head])) break;
                    drop_queue_entry(0);
                    model_queued[head] = 1'b0;
                    push_result(1'b1, head, ST_OK, ACT_NONE, '0, 1'b0);
                end
                if (model_length > 0) begin
                    push_result(1'b0, '0, ST_OK, ACT_ARM, model_expiry[model_order[0]], 1'b1);
                end else begin
                    push_result(1'b0, '0, ST_OK, ACT_CLEAR, '0, 1'b1);
                end
            end
            default: begin
                push_result(1'b0, '0, ST_OK, ACT_NONE, '0, 1'b1);
            end
        endcase
    endfunction

    // Send one command word; returns at the edge where it is accepted.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [TICK_W-1:0] tick, input logic [TICK_W-1:0] now_val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, now_val, tick, id};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_timer_command(cmd, id, tick, now_val);
    endtask

    // Hold the sender off until every outstanding result word is back.
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("result word with no expectation pending: tdata 0x%0h",
                       m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("fired", want.fired, m_axis_tuser);
                check_field("fired_id", want.fired_id, m_axis_tdata[3:0]);
                check_field("status", want.status, m_axis_tdata[4]);
                check_field("compare_action", want.action, m_axis_tdata[6:5]);
                check_field("compare_value", want.value, m_axis_tdata[38:7]);
                check_field("interrupt_count", want.irq_count, m_axis_tdata[70:39]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Ordering of starts: head arming, equal expiries, wrap and duplicates.
    task automatic test_start_rules();
        send_word(CMD_START, 4'd0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_START, 4'd0, 32'h1234_5678, 32'h0000_0000);
        send_word(CMD_START, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_START, 4'd7, 32'hFFFF_0000, 32'hFFFF_FFF0);
        send_word(CMD_START, 4'd3, 32'hFFFF_8000, 32'hFFFF_FFFF);
        send_word(CMD_START, 4'd9, 32'hFFFF_0000, 32'hFFFF_FFFF);
        // New head already due with now at its maximum: the arm value wraps.
        send_word(CMD_START, 4'd12, 32'hFF00_0000, 32'hFFFF_FFFF);
    endtask

    // Stops of a middle entry, of an absent timer and of the head.
    task automatic test_stop_rules();
        send_word(CMD_STOP, 4'd3, 32'h0, 32'h0);
        send_word(CMD_STOP, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_STOP, 4'd12, 32'h0, 32'h0);
    endtask

    // Expire events: nothing due, several due, across the wrap, empty queue.
    task automatic test_expire_rules();
        send_word(CMD_EXPIRE, 4'd0, 32'h0, 32'hFFFE_0000);
        send_word(CMD_EXPIRE, 4'd0, 32'h0, 32'hFFFF_0000);
        send_word(CMD_EXPIRE, 4'd0, 32'h0, 32'h0000_0010);
        send_word(CMD_EXPIRE, 4'd0, 32'h0, 32'h0000_0000);
        send_word(CMD_STOP, 4'd5, 32'h0, 32'h0);
        // Start at now equal to the expiry arms at now plus the guard.
        send_word(CMD_START, 4'd5, 32'h0, 32'h0);
        send_word(CMD_STOP, 4'd5, 32'h0, 32'h0);
    endtask

    task automatic test_no_operation();
        send_word(CMD_NOP, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_NOP, 4'h0, 32'h0, 32'h0);
    endtask

    function automatic logic [ID_W-1:0] pick_slot(input logic want_queued);
        logic [ID_W-1:0] id;
        for (int n = 0; n < 32; n++) begin
            id = ID_W'($urandom_range(0, ID_SPACE - 1));
            if (int'(id) < USABLE_IDS && model_queued[id] == want_queued) return id;
        end
        return ID_W'($urandom_range(0, ID_SPACE - 1));
    endfunction

    // Timer traffic: mostly plausible starts, stops and expiries around a
    // moving now, with some fully random words mixed in.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct, input logic [TICK_W-1:0] start_now);
        int pick;
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sim_now            = start_now;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_for_results();
            pick    = $urandom_range(0, 99);
            sim_now = sim_now + $urandom_range(0, 12);
            tick    = $urandom;
            id      = ID_W'($urandom_range(0, ID_SPACE - 1));
            if (pick < 42) begin
                cmd = CMD_START;
                if ($urandom_range(0, 99) < 85) id = pick_slot(1'b0);
                if ($urandom_range(0, 99) < 90) tick = sim_now + $urandom_range(0, 320) - 20;
            end else if (pick < 62) begin
                cmd = CMD_STOP;
                if ($urandom_range(0, 99) < 80) id = pick_slot(1'b1);
            end else if (pick < 92) begin
                cmd = CMD_EXPIRE;
                if ($urandom_range(0, 99) < 5) sim_now = $urandom;
                else sim_now = sim_now + $urandom_range(0, 150);
            end else begin
                cmd = CMD_W'($urandom_range(0, 3));
            end
            send_word(cmd, id, tick, sim_now);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct    = 24;
        receiver_stall_pct = 48;
        test_start_rules();
        test_stop_rules();
        test_expire_rules();
        test_no_operation();

        test_random_traffic(130, 24, 48, $urandom);
        test_random_traffic(130, 48, 24, 32'hFFFF_F000);
        test_random_traffic(140, 0, 0, $urandom);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
